// ===== rtl/core/srt_pkg.sv =====
// Shared types, codes and constants of the selective-repeat retransmit tracker.
package srt_pkg;

   localparam int MAX_CHUNKS_DEF = 32;
   localparam int AGE_W          = 16;
   localparam int ACTION_W       = 2;
   localparam int CHUNK_W        = 6;
   localparam int KIND_W         = 2;
   localparam int CMP_W          = CHUNK_W + 1;

   localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(200);
   localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACK   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHUNK_W-1:0]  chunk_count;
      logic [CHUNK_W-1:0]  chunk_index;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHUNK_W-1:0] chunk_number;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [AGE_W-1:0] next_age;
      logic             expired;
   } age_result_type;

endpackage

// ===== rtl/core/srt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srt_age_unit.sv =====
// Shared age unit: saturating increment and timeout compare for one chunk.
module srt_age_unit (
   input  logic [srt_pkg::AGE_W-1:0] cur_age,
   input  logic [srt_pkg::AGE_W-1:0] timeout,
   output srt_pkg::age_result_type   result
);

   logic [srt_pkg::AGE_W-1:0] bumped;

   always_comb begin
      bumped = (cur_age == srt_pkg::AGE_MAX) ? cur_age : cur_age + 1'b1;
      result.next_age = bumped;
      result.expired  = (bumped > timeout);
   end

endmodule

// ===== rtl/core/selective_repeat_retransmit_tracker.sv =====
// Top level of the selective-repeat retransmit tracker: sequencer, chunk flags, age memory.
//
// Channel  Direction  Ports                          Word
// req      in         req_valid req_stall req_word   action, chunk_count, chunk_index
// rsp      out        rsp_valid rsp_stall rsp_word   kind, chunk_number, last
// csr      in         csr_wr_en csr_wr_data          timeout_ticks
//
// Start: accepted in ST_IDLE, then ST_SEND issues the send words. Ack: taken in ST_IDLE; a
// rejected one passes ST_ONE. Tick: accepted in ST_IDLE, ST_READ per chunk, ST_EVAL after it
// for an outstanding one (single age-memory read port), then ST_FINISH; done goes via ST_ONE.
// Reset clears all control state directly; no clearing pass.
// rsp_stall holds the sequencer only when a word must leave and the output register is full.
module selective_repeat_retransmit_tracker #(
   parameter int MAX_CHUNKS = srt_pkg::MAX_CHUNKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  srt_pkg::req_word_type       req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output srt_pkg::rsp_word_type       rsp_word,
   input  logic                        csr_wr_en,
   input  logic [srt_pkg::AGE_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int CMP_W = srt_pkg::CMP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_ONE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic                             active_ff, active_in;
   logic [CNT_W-1:0]                 total_ff, total_in;
   logic [CNT_W-1:0]                 ack_cnt_ff, ack_cnt_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic [MAX_CHUNKS-1:0]            acked_ff, acked_in;
   logic [MAX_CHUNKS-1:0]            aged_ff, aged_in;
   logic [srt_pkg::AGE_W-1:0]        timeout_ff, timeout_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [srt_pkg::CHUNK_W-1:0]      pend_num_ff, pend_num_in;
   logic [srt_pkg::KIND_W-1:0]       one_kind_ff, one_kind_in;
   logic [srt_pkg::CHUNK_W-1:0]      one_num_ff, one_num_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   srt_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                             out_free;
   logic                             push;
   srt_pkg::rsp_word_type            push_word;
   logic                             idx_last;
   logic [IDX_W-1:0]                 cur;
   logic [IDX_W-1:0]                 ack_pos;
   logic [CMP_W-1:0]                 count_sat;

   logic                             ram_wr_en;
   logic [srt_pkg::AGE_W-1:0]        ram_wr_data;
   logic                             ram_rd_en;
   logic [srt_pkg::AGE_W-1:0]        ram_rd_data;
   logic [srt_pkg::AGE_W-1:0]        stored_age;
   srt_pkg::age_result_type          age_res;

   srt_ram #(
      .WIDTH (srt_pkg::AGE_W),
      .DEPTH (MAX_CHUNKS)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur),
      .rd_data (ram_rd_data)
   );

   srt_age_unit u_age_unit (
      .cur_age (stored_age),
      .timeout (timeout_ff),
      .result  (age_res)
   );

   assign cur        = idx_ff[IDX_W-1:0];
   assign ack_pos    = req_word.chunk_index[IDX_W-1:0];
   assign idx_last   = (CNT_W'(idx_ff + 1'b1) == total_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stored_age = aged_ff[cur] ? ram_rd_data : '0;
   assign count_sat  = (CMP_W'(req_word.chunk_count) > CMP_W'(MAX_CHUNKS)) ?
                       CMP_W'(MAX_CHUNKS) : CMP_W'(req_word.chunk_count);

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      total_in      = total_ff;
      ack_cnt_in    = ack_cnt_ff;
      idx_in        = idx_ff;
      acked_in      = acked_ff;
      aged_in       = aged_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      pend_valid_in = pend_valid_ff;
      pend_num_in   = pend_num_ff;
      one_kind_in   = one_kind_ff;
      one_num_in    = one_num_ff;
      push          = 1'b0;
      push_word     = '0;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_word.action)
                  srt_pkg::ACT_START: begin
                     acked_in   = '0;
                     aged_in    = '0;
                     ack_cnt_in = '0;
                     total_in   = CNT_W'(count_sat);
                     active_in  = 1'b1;
                     idx_in     = '0;
                     if (count_sat != '0) begin
                        state_in = ST_SEND;
                     end
                  end
                  srt_pkg::ACT_ACK: begin
                     if (!active_ff ||
                         (CMP_W'(req_word.chunk_index) >= CMP_W'(total_ff))) begin
                        one_kind_in = srt_pkg::KIND_REJECT;
                        one_num_in  = req_word.chunk_index;
                        state_in    = ST_ONE;
                     end else if (!acked_ff[ack_pos]) begin
                        acked_in[ack_pos] = 1'b1;
                        ack_cnt_in        = ack_cnt_ff + 1'b1;
                     end
                  end
                  srt_pkg::ACT_TICK: begin
                     if (active_ff) begin
                        if (ack_cnt_ff == total_ff) begin
                           one_kind_in = srt_pkg::KIND_DONE;
                           one_num_in  = '0;
                           active_in   = 1'b0;
                           state_in    = ST_ONE;
                        end else begin
                           idx_in        = '0;
                           pend_valid_in = 1'b0;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (out_free) begin
               push                   = 1'b1;
               push_word.kind         = srt_pkg::KIND_SEND;
               push_word.chunk_number = srt_pkg::CHUNK_W'(idx_ff);
               push_word.last         = idx_last;
               idx_in                 = idx_ff + 1'b1;
               if (idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ONE: begin
            if (out_free) begin
               push                   = 1'b1;
               push_word.kind         = one_kind_ff;
               push_word.chunk_number = one_num_ff;
               push_word.last         = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         ST_READ: begin
            if (acked_ff[cur]) begin
               idx_in = idx_ff + 1'b1;
               if (idx_last) begin
                  state_in = ST_FINISH;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!age_res.expired || !pend_valid_ff || out_free) begin
               ram_wr_en    = 1'b1;
               ram_wr_data  = age_res.expired ? '0 : age_res.next_age;
               aged_in[cur] = 1'b1;
               if (age_res.expired) begin
                  if (pend_valid_ff) begin
                     push                   = 1'b1;
                     push_word.kind         = srt_pkg::KIND_RESEND;
                     push_word.chunk_number = pend_num_ff;
                     push_word.last         = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_num_in   = srt_pkg::CHUNK_W'(idx_ff);
               end
               idx_in   = idx_ff + 1'b1;
               state_in = idx_last ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push                   = 1'b1;
               push_word.kind         = srt_pkg::KIND_RESEND;
               push_word.chunk_number = pend_num_ff;
               push_word.last         = 1'b1;
               pend_valid_in          = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_word_in  = push ? push_word : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         total_ff      <= '0;
         ack_cnt_ff    <= '0;
         idx_ff        <= '0;
         acked_ff      <= '0;
         aged_ff       <= '0;
         timeout_ff    <= srt_pkg::TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         total_ff      <= total_in;
         ack_cnt_ff    <= ack_cnt_in;
         idx_ff        <= idx_in;
         acked_ff      <= acked_in;
         aged_ff       <= aged_in;
         timeout_ff    <= timeout_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_num_ff <= pend_num_in;
      one_kind_ff <= one_kind_in;
      one_num_ff  <= one_num_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
